### sv/pscc_pkg.sv
// ----------------------------------------------------------------------------
// pscc_pkg
// Shared types and constants for the sensor calibrate and convert unit:
// sequencer states, status codes, register indexes and divider sizing.
// ----------------------------------------------------------------------------
package pscc_pkg;

   // Default reference clock in kHz.
   localparam int REF_CLOCK_KHZ_DEF = 50000;

   // Shared divider sizing. The dividend covers the widest conversion
   // product; the divisor covers the full-scale frequency.
   localparam int DIV_W = 48;
   localparam int DVS_W = 32;
   localparam int CNT_W = $clog2(DIV_W + 1);

   // Number of dividend bits walked for each kind of division.
   localparam logic [CNT_W-1:0] WIN_BITS   = CNT_W'(32);
   localparam logic [CNT_W-1:0] FREQ_BITS  = CNT_W'(32);
   localparam logic [CNT_W-1:0] CONV_BITS  = CNT_W'(48);

   // The slope (cal_high - cal_low) * MUL / (HI - LO) reduces to d / 4 for
   // temperature and to 2 * d / 9 for voltage. Both are taken as a product
   // with a scaled reciprocal and a right shift, exact for every difference
   // of two 16-bit calibration words.
   localparam int SLOPE_SHIFT      = 20;
   localparam int TEMP_SLOPE_RECIP = 262144;
   localparam int VOLT_SLOPE_RECIP = 233018;

   localparam logic [15:0] WIN_MAX          = 16'hFFFF;
   localparam int          TEMP_OFFSET_MDEG = 9000;

   // Calibration points and full scale per sensor kind.
   localparam int TEMP_MUL  = 10;
   localparam int TEMP_HI   = 85;
   localparam int TEMP_FULL = 200;
   localparam int VOLT_MUL  = 20;
   localparam int VOLT_HI   = 900;
   localparam int VOLT_FULL = 1000;
   localparam int MILLI     = 1000;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_PARAM = 2'd1,
      ST_RANGE = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      CSR_CAL_LOW     = 2'd0,
      CSR_CAL_HIGH    = 2'd1,
      CSR_SENSOR_KIND = 2'd2,
      CSR_TEMP_OFFSET = 2'd3
   } csr_index_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_CHECK,
      S_SLOPE,
      S_ICPT_MUL,
      S_ICPT,
      S_FS,
      S_WIN,
      S_FREQ_DIV,
      S_FREQ,
      S_CONV_MUL,
      S_CONV_DIV,
      S_CONV,
      S_DONE
   } state_type;

   typedef struct packed {
      logic             start;
      logic [CNT_W-1:0] nbits;
   } div_ctrl_type;

endpackage

### sv/pvt_sensor_calibrate_convert_unit.sv
// A valid sample passes through up to three divisions in the shared divider,
// an invalid one through the window division only, and a rejected calibration
// through none; the divider yields one quotient bit per cycle.
// A new item is taken once the previous one is finished. Reset clears the
// configuration registers, the sequencer state, the response valid and the
// last raw count to zero.
// ----------------------------------------------------------------------------
// pvt_sensor_calibrate_convert_unit
// Two-point calibration of a ring-oscillator sensor and conversion of each
// counter sample to millidegrees or millivolts, under a small sequencer.
// ----------------------------------------------------------------------------
module pvt_sensor_calibrate_convert_unit #(
   parameter int REF_CLOCK_KHZ = pscc_pkg::REF_CLOCK_KHZ_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [15:0] req_counter,
   input  logic        req_sample_valid,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_value,
   output logic [1:0]  rsp_status,
   output logic [15:0] rsp_window
);

   localparam longint      WIN_NUM_L = 64'(pscc_pkg::WIN_MAX) * 64'(REF_CLOCK_KHZ);
   localparam logic [31:0] WIN_NUM   = 32'(WIN_NUM_L);
   localparam logic signed [26:0] REF_S = 27'(REF_CLOCK_KHZ);
   localparam logic signed [16:0] REF_M = 17'(REF_CLOCK_KHZ);

   // Configuration registers.
   logic [15:0] cal_low_ff, cal_high_ff;
   logic        kind_ff, offset_ff;

   // Sequencer and datapath registers.
   pscc_pkg::state_type  state_ff, state_in;
   pscc_pkg::status_type status_ff, status_in;
   logic [15:0]          counter_ff, counter_in;
   logic                 svalid_ff, svalid_in;
   logic [20:0]          fhi_ff, fhi_in;
   logic signed [15:0]   slope_ff, slope_in;
   logic signed [25:0]   icpt_ff, icpt_in;
   logic [15:0]          win_ff, win_in;
   logic [31:0]          freq_ff, freq_in;
   logic [31:0]          value_ff, value_in;
   logic [15:0]          last_raw_ff, last_raw_in;
   logic signed [50:0]   mul_ff, mul_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [31:0]          rsp_value_ff, rsp_value_in;
   pscc_pkg::status_type rsp_status_ff, rsp_status_in;
   logic [15:0]          rsp_window_ff, rsp_window_in;

   // Shared units.
   logic signed [33:0]   mul_a;
   logic signed [16:0]   mul_b;
   pscc_pkg::div_ctrl_type                  div_ctrl;
   logic signed [pscc_pkg::DIV_W-1:0]       div_dividend;
   logic signed [pscc_pkg::DVS_W-1:0]       div_divisor;
   logic                                    div_done;
   logic signed [pscc_pkg::DIV_W-1:0]       div_quo;

   logic [20:0]          fhi;
   logic signed [33:0]   slope_mul;
   logic signed [16:0]   dcal;
   logic signed [16:0]   dcal_mag;
   logic [15:0]          slope_mag;
   logic signed [26:0]   fs;
   logic signed [33:0]   excess;
   logic [15:0]          win_clamp;
   logic signed [pscc_pkg::DIV_W-1:0] temp_q;

   pscc_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (div_ctrl),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quo)
   );

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cal_low_ff  <= '0;
         cal_high_ff <= '0;
         kind_ff     <= 1'b0;
         offset_ff   <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            pscc_pkg::CSR_CAL_LOW:     cal_low_ff  <= csr_wdata;
            pscc_pkg::CSR_CAL_HIGH:    cal_high_ff <= csr_wdata;
            pscc_pkg::CSR_SENSOR_KIND: kind_ff     <= csr_wdata[0];
            pscc_pkg::CSR_TEMP_OFFSET: offset_ff   <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      // Upper calibration frequency and slope reciprocal for the sensor kind.
      if (kind_ff) begin
         fhi       = 21'(cal_high_ff) * 21'(pscc_pkg::VOLT_MUL);
         slope_mul = 34'(pscc_pkg::VOLT_SLOPE_RECIP);
      end else begin
         fhi       = 21'(cal_high_ff) * 21'(pscc_pkg::TEMP_MUL);
         slope_mul = 34'(pscc_pkg::TEMP_SLOPE_RECIP);
      end
      dcal      = $signed({1'b0, cal_high_ff}) - $signed({1'b0, cal_low_ff});
      dcal_mag  = dcal[16] ? -dcal : dcal;
      slope_mag = mul_ff[pscc_pkg::SLOPE_SHIFT +: 16];
      fs        = 27'(mul_ff) + 27'(icpt_ff);
      excess    = $signed({2'b00, freq_ff}) - 34'(icpt_ff);
      win_clamp = (div_quo > $signed(pscc_pkg::DIV_W'(pscc_pkg::WIN_MAX))) ?
                  pscc_pkg::WIN_MAX : div_quo[15:0];
      temp_q    = offset_ff ? div_quo - pscc_pkg::DIV_W'(pscc_pkg::TEMP_OFFSET_MDEG)
                            : div_quo;

      state_in      = state_ff;
      status_in     = status_ff;
      counter_in    = counter_ff;
      svalid_in     = svalid_ff;
      fhi_in        = fhi_ff;
      slope_in      = slope_ff;
      icpt_in       = icpt_ff;
      win_in        = win_ff;
      freq_in       = freq_ff;
      value_in      = value_ff;
      last_raw_in   = last_raw_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      rsp_window_in = rsp_window_ff;

      mul_a          = '0;
      mul_b          = '0;
      div_ctrl.start = 1'b0;
      div_ctrl.nbits = pscc_pkg::WIN_BITS;
      div_dividend   = '0;
      div_divisor    = '0;
      req_ready      = 1'b0;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         pscc_pkg::S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               counter_in = req_counter;
               svalid_in  = req_sample_valid;
               state_in   = pscc_pkg::S_CHECK;
            end
         end
         pscc_pkg::S_CHECK: begin
            win_in    = '0;
            value_in  = '0;
            status_in = pscc_pkg::ST_OK;
            if (cal_low_ff == '0 || cal_high_ff == '0) begin
               status_in = pscc_pkg::ST_PARAM;
               state_in  = pscc_pkg::S_DONE;
            end else begin
               fhi_in   = fhi;
               mul_a    = slope_mul;
               mul_b    = dcal_mag;
               state_in = pscc_pkg::S_SLOPE;
            end
         end
         pscc_pkg::S_SLOPE: begin
            // The product holds the slope magnitude; the sign follows the words.
            if (slope_mag == '0) begin
               status_in = pscc_pkg::ST_PARAM;
               state_in  = pscc_pkg::S_DONE;
            end else begin
               slope_in = dcal[16] ? -slope_mag : slope_mag;
               state_in = pscc_pkg::S_ICPT_MUL;
            end
         end
         pscc_pkg::S_ICPT_MUL: begin
            mul_a    = 34'(slope_ff);
            mul_b    = kind_ff ? 17'(pscc_pkg::VOLT_HI) : 17'(pscc_pkg::TEMP_HI);
            state_in = pscc_pkg::S_ICPT;
         end
         pscc_pkg::S_ICPT: begin
            icpt_in  = $signed({5'b00000, fhi_ff}) - 26'(mul_ff);
            mul_a    = 34'(slope_ff);
            mul_b    = kind_ff ? 17'(pscc_pkg::VOLT_FULL) : 17'(pscc_pkg::TEMP_FULL);
            state_in = pscc_pkg::S_FS;
         end
         pscc_pkg::S_FS: begin
            if (fs < REF_S) begin
               status_in = pscc_pkg::ST_RANGE;
               state_in  = pscc_pkg::S_DONE;
            end else begin
               div_ctrl.start = 1'b1;
               div_ctrl.nbits = pscc_pkg::WIN_BITS;
               div_dividend   = pscc_pkg::DIV_W'(WIN_NUM);
               div_divisor    = pscc_pkg::DVS_W'(fs);
               state_in       = pscc_pkg::S_WIN;
            end
         end
         pscc_pkg::S_WIN: begin
            if (div_done) begin
               win_in = win_clamp;
               if (!svalid_ff) begin
                  value_in = 32'(last_raw_ff);
                  state_in = pscc_pkg::S_DONE;
               end else begin
                  last_raw_in = counter_ff;
                  if (win_clamp == '0) begin
                     status_in = pscc_pkg::ST_PARAM;
                     state_in  = pscc_pkg::S_DONE;
                  end else begin
                     mul_a    = $signed({18'd0, counter_ff});
                     mul_b    = REF_M;
                     state_in = pscc_pkg::S_FREQ_DIV;
                  end
               end
            end
         end
         pscc_pkg::S_FREQ_DIV: begin
            div_ctrl.start = 1'b1;
            div_ctrl.nbits = pscc_pkg::FREQ_BITS;
            div_dividend   = pscc_pkg::DIV_W'(mul_ff[31:0]);
            div_divisor    = pscc_pkg::DVS_W'(win_ff);
            state_in       = pscc_pkg::S_FREQ;
         end
         pscc_pkg::S_FREQ: begin
            if (div_done) begin
               freq_in  = div_quo[31:0];
               state_in = pscc_pkg::S_CONV_MUL;
            end
         end
         pscc_pkg::S_CONV_MUL: begin
            // Millivolts come from one division by the slope, which matches
            // scaling by a thousand and dividing it out again.
            mul_a    = excess;
            mul_b    = kind_ff ? 17'sd1 : 17'(pscc_pkg::MILLI);
            state_in = pscc_pkg::S_CONV_DIV;
         end
         pscc_pkg::S_CONV_DIV: begin
            div_ctrl.start = 1'b1;
            div_ctrl.nbits = pscc_pkg::CONV_BITS;
            div_dividend   = pscc_pkg::DIV_W'(mul_ff);
            div_divisor    = pscc_pkg::DVS_W'(slope_ff);
            state_in       = pscc_pkg::S_CONV;
         end
         pscc_pkg::S_CONV: begin
            if (div_done) begin
               value_in = kind_ff ? div_quo[31:0] : temp_q[31:0];
               state_in = pscc_pkg::S_DONE;
            end
         end
         pscc_pkg::S_DONE: begin
            // The result register frees up in the cycle its transfer completes.
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_value_in  = value_ff;
               rsp_status_in = status_ff;
               rsp_window_in = win_ff;
               state_in      = pscc_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = pscc_pkg::S_IDLE;
         end
      endcase

      mul_in = 51'(mul_a) * 51'(mul_b);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pscc_pkg::S_IDLE;
         rsp_valid_ff <= 1'b0;
         last_raw_ff  <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         last_raw_ff  <= last_raw_in;
      end
      status_ff     <= status_in;
      counter_ff    <= counter_in;
      svalid_ff     <= svalid_in;
      fhi_ff        <= fhi_in;
      slope_ff      <= slope_in;
      icpt_ff       <= icpt_in;
      win_ff        <= win_in;
      freq_ff       <= freq_in;
      value_ff      <= value_in;
      mul_ff        <= mul_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
      rsp_window_ff <= rsp_window_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_value  = rsp_value_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_window = rsp_window_ff;

endmodule

### sv/pscc_divider.sv
// ----------------------------------------------------------------------------
// pscc_divider
// Shared signed divider, one quotient bit per cycle. The quotient truncates
// toward zero. The caller gives the number of significant dividend bits.
// ----------------------------------------------------------------------------
module pscc_divider (
   input  logic                                clock,
   input  logic                                reset,
   input  pscc_pkg::div_ctrl_type              ctrl,
   input  logic signed [pscc_pkg::DIV_W-1:0]   dividend,
   input  logic signed [pscc_pkg::DVS_W-1:0]   divisor,
   output logic                                done,
   output logic signed [pscc_pkg::DIV_W-1:0]   quotient
);

   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;
   logic                          neg_ff, neg_in;
   logic [pscc_pkg::CNT_W-1:0]    cnt_ff, cnt_in;
   logic [pscc_pkg::DVS_W-1:0]    rem_ff, rem_in;
   logic [pscc_pkg::DVS_W-1:0]    dvs_ff, dvs_in;
   logic [pscc_pkg::DIV_W-1:0]    quo_ff, quo_in;

   logic [pscc_pkg::DIV_W-1:0]    dvd_mag;
   logic [pscc_pkg::DVS_W-1:0]    dvs_mag;
   logic [pscc_pkg::CNT_W-1:0]    shamt;
   logic [pscc_pkg::DVS_W:0]      shifted;
   logic [pscc_pkg::DVS_W:0]      trial;
   logic                          fits;

   always_comb begin
      dvd_mag = dividend[pscc_pkg::DIV_W-1] ? pscc_pkg::DIV_W'(-dividend)
                                            : pscc_pkg::DIV_W'(dividend);
      dvs_mag = divisor[pscc_pkg::DVS_W-1] ? pscc_pkg::DVS_W'(-divisor)
                                           : pscc_pkg::DVS_W'(divisor);
      shamt   = pscc_pkg::CNT_W'(pscc_pkg::DIV_W) - ctrl.nbits;
      shifted = {rem_ff, quo_ff[pscc_pkg::DIV_W-1]};
      trial   = shifted - {1'b0, dvs_ff};
      fits    = ~trial[pscc_pkg::DVS_W];

      busy_in = busy_ff;
      done_in = 1'b0;
      neg_in  = neg_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      quo_in  = quo_ff;

      if (ctrl.start) begin
         // Align the significant bits at the top so the walk starts there.
         busy_in = 1'b1;
         neg_in  = dividend[pscc_pkg::DIV_W-1] ^ divisor[pscc_pkg::DVS_W-1];
         cnt_in  = ctrl.nbits;
         rem_in  = '0;
         dvs_in  = dvs_mag;
         quo_in  = dvd_mag << shamt;
      end else if (busy_ff) begin
         rem_in = fits ? trial[pscc_pkg::DVS_W-1:0] : shifted[pscc_pkg::DVS_W-1:0];
         quo_in = {quo_ff[pscc_pkg::DIV_W-2:0], fits};
         cnt_in = cnt_ff - pscc_pkg::CNT_W'(1);
         if (cnt_ff == pscc_pkg::CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      neg_ff <= neg_in;
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = neg_ff ? -$signed(quo_ff) : $signed(quo_ff);

endmodule
